// ===== rtl/core/rs_two_symbol_encoder_log_domain_defines.svh =====
// Assertion macros shared by the encoder RTL.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef RS_TWO_SYMBOL_ENCODER_LOG_DOMAIN_DEFINES_SVH
`define RS_TWO_SYMBOL_ENCODER_LOG_DOMAIN_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Property checked on every clock edge outside reset.
`define RSE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// Condition in one cycle implies a condition in the next.
`define RSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);
`else
`define RSE_ASSERT(label, prop, msg)
`define RSE_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/core/rse_pkg.sv =====
`default_nettype none
package rse_pkg;

    localparam int FIELD_W = 10;
    localparam int SYM_W   = 11;
    localparam int POS_W   = 5;
    localparam int FS_W    = 4;
    localparam int CL_W    = 6;
    localparam int CFG_W   = 6;
    localparam int GEN_AW  = 5;

    localparam logic [FS_W-1:0]    FS_RESET   = 4'd4;
    localparam logic [CL_W-1:0]    CL_RESET   = 6'd8;
    localparam logic [FIELD_W-1:0] LVL_RESET  = 10'd15;

    // Register indexes of the configuration port
    localparam logic CFG_FIELD_SIZE  = 1'b0;
    localparam logic CFG_CODE_LENGTH = 1'b1;

    // Field element as exponent plus zero flag
    typedef struct packed {
        logic               zero;
        logic [FIELD_W-1:0] exp;
    } elem_t;

    localparam elem_t ZERO_ELEM = '{zero: 1'b1, exp: 10'h3FF};

    // Datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_BSTART,
        OP_TBL,
        OP_G0,
        OP_G1,
        OP_CP_RD,
        OP_CP_WR,
        OP_UP_RD,
        OP_UP_LD,
        OP_ADD0,
        OP_ADD1,
        OP_ADD2,
        OP_ADD3,
        OP_UP_WR,
        OP_UP0,
        OP_EINIT,
        OP_E_RD,
        OP_E_LD,
        OP_E_OUT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic take;
    } cmd_t;

    typedef struct packed {
        logic tbl_last;
        logic deg_more;
        logic i_one;
        logic k_last;
        logic out_free;
        logic fold_done;
    } status_t;

    // Primitive polynomial per field size
    function automatic logic [SYM_W-1:0] prim_poly(input logic [FS_W-1:0] m);
        logic [SYM_W-1:0] p;
        case (m)
            4'd2:    p = 11'h007;
            4'd3:    p = 11'h00B;
            4'd4:    p = 11'h013;
            4'd5:    p = 11'h025;
            4'd6:    p = 11'h043;
            4'd7:    p = 11'h089;
            4'd8:    p = 11'h11D;
            4'd9:    p = 11'h211;
            default: p = 11'h409;
        endcase
        return p;
    endfunction

    function automatic logic [FS_W-1:0] eff_m(input logic [FS_W-1:0] fs);
        logic [FS_W-1:0] m;
        m = fs;
        if (m < 4'd2) m = 4'd2;
        if (m > 4'd10) m = 4'd10;
        return m;
    endfunction

    function automatic logic [FIELD_W-1:0] level_of(input logic [FS_W-1:0] m);
        logic [SYM_W-1:0] t;
        t = (11'd1 << m) - 11'd1;
        return t[FIELD_W-1:0];
    endfunction

    function automatic logic [CL_W-1:0] eff_n(input logic [CL_W-1:0] cl,
                                              input logic [FIELD_W-1:0] level);
        logic [FIELD_W-1:0] t;
        t = {4'd0, cl};
        if (t > 10'd32) t = 10'd32;
        if (t > level) t = level;
        if (t < 10'd3) t = 10'd3;
        return t[CL_W-1:0];
    endfunction

    // Product: exponent sum, one conditional subtract of the level
    function automatic elem_t gf_mul(input elem_t a, input elem_t b,
                                     input logic [FIELD_W-1:0] level);
        logic [SYM_W-1:0] s;
        elem_t r;
        s = {1'b0, a.exp} + {1'b0, b.exp};
        if (s >= {1'b0, level}) s = s - {1'b0, level};
        r.zero = a.zero | b.zero;
        r.exp  = s[FIELD_W-1:0];
        return r;
    endfunction

    // One end-around fold of m-bit digits; keeps x mod (2^m - 1), never overflows
    function automatic logic [FIELD_W-1:0] fold_step(input logic [FIELD_W-1:0] x,
                                                     input logic [FS_W-1:0] m,
                                                     input logic [FIELD_W-1:0] level);
        logic [FIELD_W-1:0] hi;
        logic [FIELD_W-1:0] lo;
        hi = x >> m;
        lo = x & level;
        return hi + lo;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rs_two_symbol_encoder_log_domain.sv =====
`default_nettype none
// Two-symbol Reed-Solomon encoder over GF(2^m), symbols carried as exponents
// (all ones = zero element).
// Input channel s_*: one beat carries the information pair (first, second).
// Output channel m_*: n beats per input, symbol, position 0..n-1, last on n-1.
// Config port: cfg_we/cfg_index/cfg_wdata, index 0 field size, 1 code length;
// write only while idle. Any write forces a rebuild on the next input.
// Sequence: the input exponents are first reduced mod 2^m-1, one fold per cycle;
// each symbol then takes a coefficient RAM read, a multiply, a Zech-log add
// through the power/log RAMs (ADD0 to ADD3) and the output load, and the next
// beat is taken after the last symbol is loaded into the output register.
// The first beat after reset or a config write first sweeps the power and log
// tables and builds the generator.
// Reset: synchronous active-low aresetn; m=4, n=8, generator not built.
// Stall: a held output beat stops the encoder until m_ready; nothing is lost.
module rs_two_symbol_encoder_log_domain (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic                             cfg_index,
    input  wire logic [rse_pkg::CFG_W-1:0]        cfg_wdata,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic signed [rse_pkg::SYM_W-1:0] s_first_info,
    input  wire logic signed [rse_pkg::SYM_W-1:0] s_second_info,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic signed [rse_pkg::SYM_W-1:0]      m_symbol,
    output logic [rse_pkg::POS_W-1:0]             m_position,
    output logic                                  m_last
);

    rse_pkg::cmd_t    cmd;
    rse_pkg::status_t status;

    // Sequencer
    rse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_we  (cfg_we),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Tables, generator store and arithmetic
    rse_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_first_info  (s_first_info),
        .s_second_info (s_second_info),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_symbol      (m_symbol),
        .m_position    (m_position),
        .m_last        (m_last)
    );

endmodule
`default_nettype wire

// ===== rtl/core/rse_ram.sv =====
`default_nettype none
module rse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/rse_ctrl.sv =====
`default_nettype none
`include "rs_two_symbol_encoder_log_domain_defines.svh"
module rse_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire rse_pkg::status_t status,
    output rse_pkg::cmd_t         cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_BSTART, S_TBL, S_G0, S_G1, S_DCHK,
        S_CP_RD, S_CP_WR, S_UP_RD, S_UP_LD,
        S_ADD0, S_ADD1, S_ADD2, S_ADD3,
        S_UP_WR, S_UP0, S_EINIT, S_E_RD, S_E_LD, S_E_OUT
    } state_t;

    state_t state_reg;
    logic   gen_ready_reg;
    logic   mode_reg;      // 0: building generator, 1: encoding

    // State, generator-ready flag and add-return mode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            gen_ready_reg <= 1'b0;
            mode_reg      <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        state_reg <= gen_ready_reg ? S_EINIT : S_BSTART;
                    end
                end
                S_BSTART: begin
                    mode_reg  <= 1'b0;
                    state_reg <= S_TBL;
                end
                S_TBL:   if (status.tbl_last) state_reg <= S_G0;
                S_G0:    state_reg <= S_G1;
                S_G1:    state_reg <= S_DCHK;
                S_DCHK: begin
                    if (status.deg_more) begin
                        state_reg <= S_CP_RD;
                    end else begin
                        gen_ready_reg <= 1'b1;
                        state_reg     <= S_EINIT;
                    end
                end
                S_CP_RD: state_reg <= S_CP_WR;
                S_CP_WR: state_reg <= S_UP_RD;
                S_UP_RD: state_reg <= S_UP_LD;
                S_UP_LD: state_reg <= S_ADD0;
                S_ADD0:  state_reg <= S_ADD1;
                S_ADD1:  state_reg <= S_ADD2;
                S_ADD2:  state_reg <= S_ADD3;
                S_ADD3:  state_reg <= mode_reg ? S_E_OUT : S_UP_WR;
                S_UP_WR: state_reg <= status.i_one ? S_UP0 : S_UP_RD;
                S_UP0:   state_reg <= S_DCHK;
                // stay while the input exponents are still being folded
                S_EINIT: begin
                    if (status.fold_done) begin
                        mode_reg  <= 1'b1;
                        state_reg <= S_E_RD;
                    end
                end
                S_E_RD:  state_reg <= S_E_LD;
                S_E_LD:  state_reg <= S_ADD0;
                S_E_OUT: begin
                    if (status.out_free) begin
                        state_reg <= status.k_last ? S_IDLE : S_E_RD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            // any register write forces a rebuild
            if (cfg_we) begin
                gen_ready_reg <= 1'b0;
            end
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    // Command decode
    always_comb begin
        cmd.take = s_valid && (state_reg == S_IDLE);
        unique case (state_reg)
            S_BSTART: cmd.op = rse_pkg::OP_BSTART;
            S_TBL:    cmd.op = rse_pkg::OP_TBL;
            S_G0:     cmd.op = rse_pkg::OP_G0;
            S_G1:     cmd.op = rse_pkg::OP_G1;
            S_CP_RD:  cmd.op = rse_pkg::OP_CP_RD;
            S_CP_WR:  cmd.op = rse_pkg::OP_CP_WR;
            S_UP_RD:  cmd.op = rse_pkg::OP_UP_RD;
            S_UP_LD:  cmd.op = rse_pkg::OP_UP_LD;
            S_ADD0:   cmd.op = rse_pkg::OP_ADD0;
            S_ADD1:   cmd.op = rse_pkg::OP_ADD1;
            S_ADD2:   cmd.op = rse_pkg::OP_ADD2;
            S_ADD3:   cmd.op = rse_pkg::OP_ADD3;
            S_UP_WR:  cmd.op = rse_pkg::OP_UP_WR;
            S_UP0:    cmd.op = rse_pkg::OP_UP0;
            S_EINIT:  cmd.op = rse_pkg::OP_EINIT;
            S_E_RD:   cmd.op = rse_pkg::OP_E_RD;
            S_E_LD:   cmd.op = rse_pkg::OP_E_LD;
            S_E_OUT:  cmd.op = status.out_free ? rse_pkg::OP_E_OUT : rse_pkg::OP_NONE;
            default:  cmd.op = rse_pkg::OP_NONE;
        endcase
    end

    `RSE_ASSERT(a_ready_from_build, $rose(gen_ready_reg) |-> $past(state_reg == S_DCHK), "generator ready set outside build")
    `RSE_ASSERT_NEXT(a_out_hold, (state_reg == S_E_OUT) && !status.out_free, state_reg == S_E_OUT, "left output state while stalled")

endmodule
`default_nettype wire

// ===== rtl/core/rse_datapath.sv =====
`default_nettype none
`include "rs_two_symbol_encoder_log_domain_defines.svh"
module rse_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire rse_pkg::cmd_t                 cmd,
    output rse_pkg::status_t                   status,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [rse_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic signed [rse_pkg::SYM_W-1:0] s_first_info,
    input  wire logic signed [rse_pkg::SYM_W-1:0] s_second_info,
    input  wire logic                          m_ready,
    output logic                               m_valid,
    output logic signed [rse_pkg::SYM_W-1:0]   m_symbol,
    output logic [rse_pkg::POS_W-1:0]          m_position,
    output logic                               m_last
);

    logic [rse_pkg::FS_W-1:0]    field_size_reg;
    logic [rse_pkg::CL_W-1:0]    code_length_reg;
    logic [rse_pkg::FS_W-1:0]    m_reg;
    logic [rse_pkg::FIELD_W-1:0] level_reg;
    logic [rse_pkg::CL_W-1:0]    n_reg;
    logic [rse_pkg::FIELD_W-1:0] lfsr_reg;
    logic [rse_pkg::FIELD_W-1:0] idx_reg;
    logic [rse_pkg::SYM_W-1:0]   u_raw_reg;
    logic [rse_pkg::SYM_W-1:0]   v_raw_reg;
    rse_pkg::elem_t              u_reg;
    rse_pkg::elem_t              v_reg;
    logic [rse_pkg::GEN_AW-1:0]  deg_reg;
    logic [rse_pkg::GEN_AW-1:0]  i_reg;
    logic [rse_pkg::GEN_AW-1:0]  k_reg;
    rse_pkg::elem_t              cur_reg;
    rse_pkg::elem_t              opa_reg;
    rse_pkg::elem_t              opb_reg;
    rse_pkg::elem_t              res_reg;
    logic [rse_pkg::FIELD_W-1:0] px_reg;
    logic                        m_valid_reg;
    logic [rse_pkg::SYM_W-1:0]   sym_reg;
    logic [rse_pkg::POS_W-1:0]   pos_reg;
    logic                        last_reg;

    logic [rse_pkg::FIELD_W-1:0] pw_rdata;
    logic [rse_pkg::FIELD_W-1:0] lg_rdata;
    logic [rse_pkg::FIELD_W-1:0] pw_raddr;
    logic [rse_pkg::FIELD_W-1:0] lg_raddr;
    logic [rse_pkg::SYM_W-1:0]   gen_rdata;
    logic [rse_pkg::SYM_W-1:0]   gen_wdata;
    logic [rse_pkg::GEN_AW-1:0]  gen_waddr;
    logic [rse_pkg::GEN_AW-1:0]  gen_raddr;
    logic                        gen_we;
    logic                        tbl_we;
    rse_pkg::elem_t              g_rd;
    rse_pkg::elem_t              gk;
    rse_pkg::elem_t              root;
    rse_pkg::elem_t              add_res;
    logic [rse_pkg::SYM_W-1:0]   lfsr_sh;
    logic [rse_pkg::FS_W-1:0]    m_new;
    logic [rse_pkg::FIELD_W-1:0] level_new;

    // Power and log tables, written together during the table sweep
    assign tbl_we   = (cmd.op == rse_pkg::OP_TBL);
    assign pw_raddr = (cmd.op == rse_pkg::OP_ADD1) ? opb_reg.exp : opa_reg.exp;
    assign lg_raddr = pw_rdata ^ px_reg;

    rse_ram #(.WIDTH(rse_pkg::FIELD_W), .DEPTH(1 << rse_pkg::FIELD_W)) u_power (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (idx_reg),
        .wdata (lfsr_reg),
        .raddr (pw_raddr),
        .rdata (pw_rdata)
    );

    rse_ram #(.WIDTH(rse_pkg::FIELD_W), .DEPTH(1 << rse_pkg::FIELD_W)) u_log (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (lfsr_reg),
        .wdata (idx_reg),
        .raddr (lg_raddr),
        .rdata (lg_rdata)
    );

    // Generator coefficient store
    assign g_rd = rse_pkg::elem_t'(gen_rdata);
    assign root = '{zero: 1'b0, exp: {5'd0, deg_reg} + 10'd1};

    always_comb begin
        gen_we    = 1'b1;
        gen_waddr = '0;
        gen_wdata = rse_pkg::ZERO_ELEM;
        unique case (cmd.op)
            rse_pkg::OP_G0: gen_wdata = {1'b0, 10'd1};
            rse_pkg::OP_G1: begin
                gen_waddr = 5'd1;
                gen_wdata = {1'b0, 10'd0};
            end
            rse_pkg::OP_CP_WR: begin
                gen_waddr = deg_reg + 5'd1;
                gen_wdata = g_rd;
            end
            rse_pkg::OP_UP_WR: begin
                gen_waddr = i_reg;
                gen_wdata = res_reg;
            end
            rse_pkg::OP_UP0: gen_wdata = rse_pkg::gf_mul(root, cur_reg, level_reg);
            default: gen_we = 1'b0;
        endcase
    end

    always_comb begin
        unique case (cmd.op)
            rse_pkg::OP_CP_RD: gen_raddr = deg_reg;
            rse_pkg::OP_UP_RD: gen_raddr = i_reg - 5'd1;
            default:           gen_raddr = k_reg;
        endcase
    end

    rse_ram #(.WIDTH(rse_pkg::SYM_W), .DEPTH(1 << rse_pkg::GEN_AW)) u_gen (
        .aclk  (aclk),
        .we    (gen_we),
        .waddr (gen_waddr),
        .wdata (gen_wdata),
        .raddr (gen_raddr),
        .rdata (gen_rdata)
    );

    // Zech-log add, result taken in the last add cycle
    always_comb begin
        priority if (opa_reg.zero) begin
            add_res = opb_reg;
        end else if (opb_reg.zero) begin
            add_res = opa_reg;
        end else if (opa_reg.exp == opb_reg.exp) begin
            add_res = rse_pkg::ZERO_ELEM;
        end else begin
            add_res = '{zero: 1'b0, exp: lg_rdata};
        end
    end

    // Coefficient beyond the top of g counts as zero
    assign gk = ({1'b0, k_reg} + 6'd1 < n_reg) ? g_rd : rse_pkg::ZERO_ELEM;

    // Next power-table vector
    always_comb begin
        lfsr_sh = {lfsr_reg, 1'b0};
        if (lfsr_sh[m_reg]) lfsr_sh = lfsr_sh ^ rse_pkg::prim_poly(m_reg);
    end

    assign m_new     = rse_pkg::eff_m(field_size_reg);
    assign level_new = rse_pkg::level_of(m_new);

    // Control-side registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_size_reg  <= rse_pkg::FS_RESET;
            code_length_reg <= rse_pkg::CL_RESET;
            m_reg           <= rse_pkg::FS_RESET;
            level_reg       <= rse_pkg::LVL_RESET;
            n_reg           <= rse_pkg::CL_RESET;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    rse_pkg::CFG_FIELD_SIZE:  field_size_reg  <= cfg_wdata[rse_pkg::FS_W-1:0];
                    rse_pkg::CFG_CODE_LENGTH: code_length_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.op == rse_pkg::OP_BSTART) begin
                m_reg     <= m_new;
                level_reg <= level_new;
                n_reg     <= rse_pkg::eff_n(code_length_reg, level_new);
            end
            if (cmd.op == rse_pkg::OP_E_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            u_raw_reg <= s_first_info;
            v_raw_reg <= s_second_info;
        end
        unique case (cmd.op)
            rse_pkg::OP_BSTART: begin
                lfsr_reg <= 10'd1;
                idx_reg  <= '0;
            end
            rse_pkg::OP_TBL: begin
                lfsr_reg <= lfsr_sh[rse_pkg::FIELD_W-1:0];
                idx_reg  <= idx_reg + 10'd1;
            end
            rse_pkg::OP_G0: deg_reg <= 5'd1;
            rse_pkg::OP_CP_WR: begin
                cur_reg <= g_rd;
                i_reg   <= deg_reg;
            end
            rse_pkg::OP_UP_LD: begin
                opa_reg <= g_rd;
                opb_reg <= rse_pkg::gf_mul(root, cur_reg, level_reg);
                cur_reg <= g_rd;
            end
            rse_pkg::OP_ADD1: px_reg <= pw_rdata;
            rse_pkg::OP_ADD3: res_reg <= add_res;
            rse_pkg::OP_UP_WR: i_reg <= i_reg - 5'd1;
            rse_pkg::OP_UP0: deg_reg <= deg_reg + 5'd1;
            // fold the input exponents one step a cycle, then load them
            rse_pkg::OP_EINIT: begin
                if (status.fold_done) begin
                    u_reg.zero <= u_raw_reg[rse_pkg::SYM_W-1];
                    u_reg.exp  <= (u_raw_reg[rse_pkg::FIELD_W-1:0] == level_reg) ?
                                  '0 : u_raw_reg[rse_pkg::FIELD_W-1:0];
                    v_reg.zero <= v_raw_reg[rse_pkg::SYM_W-1];
                    v_reg.exp  <= (v_raw_reg[rse_pkg::FIELD_W-1:0] == level_reg) ?
                                  '0 : v_raw_reg[rse_pkg::FIELD_W-1:0];
                    k_reg      <= '0;
                    cur_reg    <= rse_pkg::ZERO_ELEM;
                end else begin
                    u_raw_reg[rse_pkg::FIELD_W-1:0] <=
                        rse_pkg::fold_step(u_raw_reg[rse_pkg::FIELD_W-1:0], m_reg, level_reg);
                    v_raw_reg[rse_pkg::FIELD_W-1:0] <=
                        rse_pkg::fold_step(v_raw_reg[rse_pkg::FIELD_W-1:0], m_reg, level_reg);
                end
            end
            rse_pkg::OP_E_LD: begin
                opa_reg <= rse_pkg::gf_mul(u_reg, gk, level_reg);
                opb_reg <= rse_pkg::gf_mul(v_reg, cur_reg, level_reg);
                cur_reg <= gk;
            end
            rse_pkg::OP_E_OUT: begin
                sym_reg  <= res_reg.zero ? 11'h7FF : {1'b0, res_reg.exp};
                pos_reg  <= k_reg;
                last_reg <= ({1'b0, k_reg} == n_reg - 6'd1);
                k_reg    <= k_reg + 5'd1;
            end
            default: ;
        endcase
    end

    // Status to the controller
    assign status.tbl_last  = (idx_reg == level_reg - 10'd1);
    assign status.deg_more  = ({1'b0, deg_reg} + 6'd2 < n_reg);
    assign status.i_one     = (i_reg == 5'd1);
    assign status.k_last    = ({1'b0, k_reg} == n_reg - 6'd1);
    assign status.out_free  = !m_valid_reg || m_ready;
    assign status.fold_done = (u_raw_reg[rse_pkg::FIELD_W-1:0] <= level_reg) &&
                              (v_raw_reg[rse_pkg::FIELD_W-1:0] <= level_reg);

    assign m_valid    = m_valid_reg;
    assign m_symbol   = signed'(sym_reg);
    assign m_position = pos_reg;
    assign m_last     = last_reg;

    `RSE_ASSERT(a_n_range, (n_reg >= 6'd3) && (10'(n_reg) <= level_reg), "code length out of range")
    `RSE_ASSERT(a_out_load, (cmd.op == rse_pkg::OP_E_OUT) |-> (!m_valid_reg || m_ready), "output overwritten")

endmodule
`default_nettype wire
